/* design/afs_pkg.sv */
package afs_pkg;

    // Field widths
    localparam int SAMPLE_W = 24;
    localparam int VALUE_W  = 23;
    localparam int GAIN_W   = 16;
    localparam int SUM_W    = 40;
    localparam int NUM_CH   = 8;
    localparam int QTY_W    = 4;
    localparam int KIND_W   = 2;

    // Default build parameters
    localparam int NUM_CELLS_DEF  = 7;
    localparam int COUNT_BITS_DEF = 16;

    // Serial multiplier shape: signed operand by unsigned operand
    localparam int MUL_AW = 48;
    localparam int MUL_BW = 21;
    localparam int MUL_PW = MUL_AW + MUL_BW;

    // Scale factors, 1/16 unit steps
    localparam logic [MUL_BW-1:0] CUR_SCALE  = 21'd1200000;
    localparam logic [MUL_BW-1:0] CELL_SCALE = 21'd281600;
    localparam logic [MUL_BW-1:0] FILT_COEF  = 21'd10879;
    localparam int CUR_BIAS = 453;

    // Frame kinds
    localparam logic [KIND_W-1:0] KIND_IGNORE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CAL    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FINISH = 2'd2;
    localparam logic [KIND_W-1:0] KIND_MEAS   = 2'd3;

    // Quantity codes
    localparam logic [QTY_W-1:0] QTY_CURRENT = 4'd0;
    localparam logic [QTY_W-1:0] QTY_PACK    = 4'd8;

    // Register indexes
    localparam logic [2:0] REG_CELL_ENABLE = 3'd0;

    localparam logic [GAIN_W-1:0] GAIN_RESET [0:6] = '{
        16'd33796, 16'd32805, 16'd33569, 16'd32418, 16'd33192, 16'd33832, 16'd32350
    };

    // Round to nearest, halves up, then floor shift
    function automatic logic signed [MUL_PW-1:0] round_shift(
        input logic signed [MUL_PW-1:0] v,
        input int unsigned s
    );
        logic signed [MUL_PW-1:0] t;
        t = v + (MUL_PW'(1) << (s - 1));
        return t >>> s;
    endfunction

    // Saturate to signed 23 bits
    function automatic logic signed [VALUE_W-1:0] sat23(input logic signed [MUL_PW-1:0] v);
        if (v > $signed(MUL_PW'(4194303)))
            return 23'sh3FFFFF;
        else if (v < -$signed(MUL_PW'(4194304)))
            return 23'sh400000;
        else
            return v[VALUE_W-1:0];
    endfunction

endpackage

/* design/afs_mul.sv */
// Bit-serial shift-add multiplier: one multiplier bit per cycle.
module afs_mul #(
    parameter int AW = afs_pkg::MUL_AW,
    parameter int BW = afs_pkg::MUL_BW
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [AW-1:0]    a,
    input  logic        [BW-1:0]    b,
    output logic                    busy,
    output logic                    done,
    output logic signed [AW+BW-1:0] p
);
    localparam int PW = AW + BW;
    localparam int CW = $clog2(BW + 1);

    logic signed [PW-1:0] a_reg;
    logic        [BW-1:0] b_reg;
    logic signed [PW-1:0] acc_reg;
    logic        [CW-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    // Step: add shifted multiplicand when the multiplier bit is set
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                a_reg    <= PW'(a);
                b_reg    <= b;
                acc_reg  <= '0;
                cnt_reg  <= CW'(BW);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (b_reg[0])
                    acc_reg <= acc_reg + a_reg;
                a_reg   <= a_reg <<< 1;
                b_reg   <= b_reg >> 1;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign p    = acc_reg;

endmodule

/* design/afs_div.sv */
// Restoring divider, one quotient bit per cycle, truncates toward zero.
module afs_div #(
    parameter int DW = afs_pkg::SUM_W,
    parameter int CW = afs_pkg::COUNT_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [DW-1:0] dividend,
    input  logic        [CW-1:0] divisor,
    output logic                 done,
    output logic signed [DW-1:0] quotient
);
    localparam int NW = $clog2(DW + 1);

    logic [DW-1:0] n_reg;
    logic [CW-1:0] rem_reg;
    logic [CW-1:0] d_reg;
    logic          neg_reg;
    logic [NW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [CW:0]   trial;
    logic          fits;

    assign trial = {rem_reg, n_reg[DW-1]};
    assign fits  = trial >= {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                n_reg    <= dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
                neg_reg  <= dividend[DW-1];
                d_reg    <= divisor;
                rem_reg  <= '0;
                cnt_reg  <= NW'(DW);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= fits ? CW'(trial - {1'b0, d_reg}) : trial[CW-1:0];
                n_reg   <= {n_reg[DW-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == NW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(n_reg) : $signed(n_reg);

endmodule

/* design/adc_frame_scale_filter_calibrate_unit.sv */
// Channel  Dir  Handshake          Payload
// s_       in   s_tvalid/s_tready  tuser: kind; tdata: sample_ch0..ch7
// m_       out  m_tvalid/m_tready  tuser: quantity; tdata: instant, filtered; tlast
// cfg_     in   cfg_we             cfg_index, cfg_data
//
// One frame at a time; s_tready is high only while idle.
// Every product runs through one bit-serial multiplier, and a measure frame
// takes up to 24 products.
// Finishing calibration runs a divider and a product per channel.
// A stalled m_tready holds the sequencer at the emit step of the next result.
// Reset clears all filters, offsets, sums and the count at once.
module adc_frame_scale_filter_calibrate_unit #(
    parameter int NUM_CELLS  = afs_pkg::NUM_CELLS_DEF,
    parameter int COUNT_BITS = afs_pkg::COUNT_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [191:0] s_tdata,   // sample_ch0 [23:0] .. sample_ch7 [191:168]
    input  logic [1:0]   s_tuser,   // kind
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [47:0]  m_tdata,   // instant_value [22:0], filtered_value [45:23], zeros
    output logic [3:0]   m_tuser,   // quantity
    output logic         m_tlast,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_data
);
    localparam int PW = afs_pkg::MUL_PW;
    localparam int VW = afs_pkg::VALUE_W;

    typedef enum logic [2:0] {
        S_IDLE, S_ACC, S_FIN, S_DIV, S_DWAIT, S_MUL, S_MWAIT, S_EMIT
    } state_t;

    typedef enum logic [1:0] {
        PH_SCALE, PH_GAIN, PH_FILT, PH_OFFSET
    } phase_t;

    state_t state_reg;
    phase_t phase_reg;
    logic [3:0] ch_reg;
    logic [1:0] kind_reg;

    logic signed [afs_pkg::SAMPLE_W-1:0] raw_reg [0:7];
    logic signed [VW-1:0] filt_reg [0:8];
    logic signed [VW-1:0] off_reg [0:7];
    logic signed [afs_pkg::SUM_W-1:0] sum_reg [0:7];
    logic [COUNT_BITS-1:0] count_reg;
    logic [afs_pkg::GAIN_W-1:0] gain_reg [0:6];
    logic enable_reg;

    logic signed [24:0] diff_reg;
    logic signed [VW-1:0] x_reg;
    logic signed [VW-1:0] fout_reg;
    logic signed [25:0] pack_reg;
    logic signed [afs_pkg::SUM_W-1:0] quot_reg;

    logic out_valid_reg;
    logic [3:0] out_q_reg;
    logic signed [VW-1:0] out_inst_reg;
    logic signed [VW-1:0] out_filt_reg;
    logic out_last_reg;

    // Multiplier and divider hookup
    logic mul_start, mul_busy, mul_done;
    logic signed [afs_pkg::MUL_AW-1:0] mul_a;
    logic [afs_pkg::MUL_BW-1:0] mul_b;
    logic signed [PW-1:0] mul_p;
    logic div_start, div_done;
    logic signed [afs_pkg::SUM_W-1:0] div_q;

    logic [2:0] g_idx;
    logic signed [PW-1:0] r24, r15, r16;
    logic signed [VW-1:0] f_new;
    logic last_cell;

    assign g_idx     = 3'(ch_reg - 4'd1);
    assign last_cell = ch_reg == 4'(NUM_CELLS);
    assign mul_start = state_reg == S_MUL;
    assign div_start = state_reg == S_DIV;

    // Operand selection for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (phase_reg)
            PH_SCALE:
            begin
                mul_a = afs_pkg::MUL_AW'(raw_reg[ch_reg[2:0]]);
                mul_b = (ch_reg == 4'd0) ? afs_pkg::CUR_SCALE : afs_pkg::CELL_SCALE;
            end
            PH_GAIN:
            begin
                mul_a = afs_pkg::MUL_AW'(diff_reg);
                mul_b = afs_pkg::MUL_BW'(gain_reg[g_idx]);
            end
            PH_FILT:
            begin
                mul_a = afs_pkg::MUL_AW'(24'(x_reg) - 24'(filt_reg[ch_reg]));
                mul_b = afs_pkg::FILT_COEF;
            end
            PH_OFFSET:
            begin
                mul_a = afs_pkg::MUL_AW'(quot_reg);
                mul_b = (ch_reg == 4'd0) ? afs_pkg::CUR_SCALE : afs_pkg::CELL_SCALE;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Rounded forms of the product
    always_comb
    begin
        r24   = afs_pkg::round_shift(mul_p, 24);
        r15   = afs_pkg::round_shift(mul_p, 15);
        r16   = afs_pkg::round_shift(mul_p, 16);
        f_new = afs_pkg::sat23(PW'(filt_reg[ch_reg]) + r16);
    end

    afs_mul #(
        .AW(afs_pkg::MUL_AW),
        .BW(afs_pkg::MUL_BW)
    ) u_mul (
        .clk(clk),
        .rst_n(rst_n),
        .start(mul_start),
        .a(mul_a),
        .b(mul_b),
        .busy(mul_busy),
        .done(mul_done),
        .p(mul_p)
    );

    afs_div #(
        .DW(afs_pkg::SUM_W),
        .CW(COUNT_BITS)
    ) u_div (
        .clk(clk),
        .rst_n(rst_n),
        .start(div_start),
        .dividend(sum_reg[ch_reg[2:0]]),
        .divisor(count_reg),
        .done(div_done),
        .quotient(div_q)
    );

    // Sequencer, state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_SCALE;
            ch_reg        <= '0;
            kind_reg      <= afs_pkg::KIND_IGNORE;
            count_reg     <= '0;
            enable_reg    <= 1'b1;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 9; i++)
                filt_reg[i] <= '0;
            for (int i = 0; i < 8; i++)
            begin
                off_reg[i] <= '0;
                sum_reg[i] <= '0;
            end
            for (int i = 0; i < 7; i++)
                gain_reg[i] <= afs_pkg::GAIN_RESET[i];
        end
        else
        begin
            // Beat taken; the emit step reloads the register itself
            if (m_tvalid && m_tready && state_reg != S_EMIT)
                out_valid_reg <= 1'b0;

            // Register writes
            if (cfg_we)
            begin
                if (cfg_index == afs_pkg::REG_CELL_ENABLE)
                    enable_reg <= cfg_data[0];
                else
                    gain_reg[3'(cfg_index - 3'd1)] <= cfg_data;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        for (int i = 0; i < 8; i++)
                            raw_reg[i] <= s_tdata[i*24 +: 24];
                        kind_reg <= s_tuser;
                        ch_reg   <= '0;
                        pack_reg <= '0;
                        phase_reg <= PH_SCALE;
                        if (s_tuser == afs_pkg::KIND_CAL || s_tuser == afs_pkg::KIND_FINISH)
                            state_reg <= S_ACC;
                        else if (s_tuser == afs_pkg::KIND_MEAS)
                            state_reg <= S_MUL;
                    end
                end
                S_ACC:
                begin
                    if (count_reg != {COUNT_BITS{1'b1}})
                    begin
                        for (int i = 0; i < 8; i++)
                        begin
                            if (i <= NUM_CELLS)
                            begin
                                logic signed [afs_pkg::SUM_W:0] s;
                                s = 41'(sum_reg[i]) + 41'(raw_reg[i]);
                                if (s > 41'sd549755813887)
                                    sum_reg[i] <= 40'sh7FFFFFFFFF;
                                else if (s < -41'sd549755813888)
                                    sum_reg[i] <= 40'sh8000000000;
                                else
                                    sum_reg[i] <= s[afs_pkg::SUM_W-1:0];
                            end
                        end
                        count_reg <= count_reg + 1'b1;
                    end
                    state_reg <= (kind_reg == afs_pkg::KIND_FINISH) ? S_FIN : S_IDLE;
                end
                S_FIN:
                begin
                    if (count_reg != '0)
                        state_reg <= S_DIV;
                    else
                    begin
                        for (int i = 0; i < 8; i++)
                            sum_reg[i] <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                S_DIV:
                begin
                    state_reg <= S_DWAIT;
                end
                S_DWAIT:
                begin
                    if (div_done)
                    begin
                        quot_reg  <= div_q;
                        phase_reg <= PH_OFFSET;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_MWAIT;
                end
                S_MWAIT:
                begin
                    if (mul_done)
                    begin
                        case (phase_reg)
                            PH_SCALE:
                            begin
                                if (ch_reg == 4'd0)
                                begin
                                    x_reg <= afs_pkg::sat23(r24 - PW'(off_reg[0])
                                        - PW'(afs_pkg::CUR_BIAS));
                                    phase_reg <= PH_FILT;
                                end
                                else
                                begin
                                    diff_reg  <= 25'(r24 - PW'(off_reg[ch_reg[2:0]]));
                                    phase_reg <= PH_GAIN;
                                end
                                state_reg <= S_MUL;
                            end
                            PH_GAIN:
                            begin
                                x_reg     <= afs_pkg::sat23(r15);
                                phase_reg <= PH_FILT;
                                state_reg <= S_MUL;
                            end
                            PH_FILT:
                            begin
                                filt_reg[ch_reg] <= f_new;
                                fout_reg <= f_new;
                                if (ch_reg != 4'd0 && ch_reg != afs_pkg::QTY_PACK)
                                    pack_reg <= pack_reg + 26'(f_new);
                                state_reg <= S_EMIT;
                            end
                            PH_OFFSET:
                            begin
                                off_reg[ch_reg[2:0]] <= afs_pkg::sat23(r24);
                                if (last_cell)
                                begin
                                    for (int i = 0; i < 8; i++)
                                        sum_reg[i] <= '0;
                                    count_reg <= '0;
                                    state_reg <= S_IDLE;
                                end
                                else
                                begin
                                    ch_reg    <= ch_reg + 4'd1;
                                    state_reg <= S_DIV;
                                end
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_EMIT:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_q_reg     <= ch_reg;
                        out_inst_reg  <= x_reg;
                        out_filt_reg  <= fout_reg;
                        out_last_reg  <= (ch_reg == afs_pkg::QTY_PACK)
                            || (ch_reg == afs_pkg::QTY_CURRENT && !enable_reg);
                        phase_reg <= PH_SCALE;
                        if (ch_reg == afs_pkg::QTY_CURRENT)
                        begin
                            if (enable_reg)
                            begin
                                ch_reg    <= 4'd1;
                                state_reg <= S_MUL;
                            end
                            else
                                state_reg <= S_IDLE;
                        end
                        else if (ch_reg == afs_pkg::QTY_PACK)
                            state_reg <= S_IDLE;
                        else if (last_cell)
                        begin
                            ch_reg    <= afs_pkg::QTY_PACK;
                            x_reg     <= afs_pkg::sat23(PW'(pack_reg));
                            phase_reg <= PH_FILT;
                            state_reg <= S_MUL;
                        end
                        else
                        begin
                            ch_reg    <= ch_reg + 4'd1;
                            state_reg <= S_MUL;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_filt_reg, out_inst_reg};
    assign m_tuser  = out_q_reg;
    assign m_tlast  = out_last_reg;

    // Shared units finish only while the sequencer waits for them
    a_mul_done: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> state_reg == S_MWAIT)
        else $error("multiplier finished outside its wait step");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DWAIT)
        else $error("divider finished outside its wait step");

    a_accept_free: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |-> !mul_busy)
        else $error("frame accepted while a product is in flight");

endmodule

/* dv/afs_checker.sv */
`timescale 1ns / 1ps

module afs_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [191:0] s_tdata,   // sample_ch0 [23:0] .. sample_ch7 [191:168]
    input  logic [1:0]   s_tuser,   // kind
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [47:0]  m_tdata,   // instant_value [22:0], filtered_value [45:23], zeros
    input  logic [3:0]   m_tuser,   // quantity
    input  logic         m_tlast,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_data,
    output int           fail_count,
    output int           pending
);

    localparam longint V_HI = 4194303;
    localparam longint V_LO = -4194304;
    localparam longint S_HI = 64'sd549755813887;
    localparam longint S_LO = -64'sd549755813888;
    localparam int unsigned COUNT_MAX = (1 << afs_pkg::COUNT_BITS_DEF) - 1;

    typedef struct {
        logic [afs_pkg::QTY_W-1:0]          qty;
        logic signed [afs_pkg::VALUE_W-1:0] inst;
        logic signed [afs_pkg::VALUE_W-1:0] filt;
        logic                               last;
    } reading_t;

    reading_t    readings_due[$];

    // Shadow of the block's state and registers
    bit          cells_on;
    longint      gain [afs_pkg::NUM_CELLS_DEF];
    longint      cur_filt, pack_filt, cur_off;
    longint      cell_filt [afs_pkg::NUM_CELLS_DEF];
    longint      cell_off [afs_pkg::NUM_CELLS_DEF];
    longint      cal_sum [afs_pkg::NUM_CH];
    int unsigned cal_cnt;

    function automatic longint rnd(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp23(longint v);
        if (v > V_HI)
            return V_HI;
        if (v < V_LO)
            return V_LO;
        return v;
    endfunction

    function automatic longint smooth(longint prev, longint x);
        return clamp23(prev + rnd((x - prev) * longint'(afs_pkg::FILT_COEF), 16));
    endfunction

    task automatic report(string what, int got, int want);
        $display("MISMATCH %0t: %s got %0d expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    task automatic push_reading(int q, longint inst, longint filt, bit last);
        reading_t r;
        r.qty  = q[afs_pkg::QTY_W-1:0];
        r.inst = inst[afs_pkg::VALUE_W-1:0];
        r.filt = filt[afs_pkg::VALUE_W-1:0];
        r.last = last;
        readings_due.push_back(r);
    endtask

    // Work out the readings one frame produces and advance the shadow state
    task automatic process_frame(logic [1:0] kind, logic [191:0] d);
        longint raw [afs_pkg::NUM_CH];
        longint v, diff, pack, cnt, s;
        for (int i = 0; i < afs_pkg::NUM_CH; i++)
            raw[i] = $signed(d[24*i +: 24]);
        if (kind == afs_pkg::KIND_CAL || kind == afs_pkg::KIND_FINISH) begin
            if (cal_cnt < COUNT_MAX) begin
                for (int i = 0; i <= afs_pkg::NUM_CELLS_DEF; i++) begin
                    s = cal_sum[i] + raw[i];
                    if (s > S_HI)
                        s = S_HI;
                    if (s < S_LO)
                        s = S_LO;
                    cal_sum[i] = s;
                end
                cal_cnt++;
            end
            if (kind == afs_pkg::KIND_FINISH) begin
                if (cal_cnt != 0) begin
                    cnt = longint'(cal_cnt);
                    cur_off = clamp23(rnd((cal_sum[0] / cnt)
                                          * longint'(afs_pkg::CUR_SCALE), 24));
                    for (int i = 0; i < afs_pkg::NUM_CELLS_DEF; i++)
                        cell_off[i] = clamp23(rnd((cal_sum[i+1] / cnt)
                                                  * longint'(afs_pkg::CELL_SCALE), 24));
                end
                foreach (cal_sum[i])
                    cal_sum[i] = 0;
                cal_cnt = 0;
            end
        end
        else if (kind == afs_pkg::KIND_MEAS) begin
            v = clamp23(rnd(raw[0] * longint'(afs_pkg::CUR_SCALE), 24) - cur_off
                        - afs_pkg::CUR_BIAS);
            cur_filt = smooth(cur_filt, v);
            push_reading(afs_pkg::QTY_CURRENT, v, cur_filt, !cells_on);
            if (cells_on) begin
                pack = 0;
                for (int i = 0; i < afs_pkg::NUM_CELLS_DEF; i++) begin
                    diff = rnd(raw[i+1] * longint'(afs_pkg::CELL_SCALE), 24) - cell_off[i];
                    v = clamp23(rnd(diff * gain[i], 15));
                    cell_filt[i] = smooth(cell_filt[i], v);
                    pack += cell_filt[i];
                    push_reading(i + 1, v, cell_filt[i], 1'b0);
                end
                v = clamp23(pack);
                pack_filt = smooth(pack_filt, v);
                push_reading(afs_pkg::QTY_PACK, v, pack_filt, 1'b1);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        reading_t want;
        if (!rst_n) begin
            cells_on  = 1'b1;
            for (int i = 0; i < afs_pkg::NUM_CELLS_DEF; i++) begin
                gain[i]      = afs_pkg::GAIN_RESET[i];
                cell_filt[i] = 0;
                cell_off[i]  = 0;
            end
            foreach (cal_sum[i])
                cal_sum[i] = 0;
            cur_filt  = 0;
            pack_filt = 0;
            cur_off   = 0;
            cal_cnt   = 0;
            readings_due.delete();
        end
        else begin
            // Compare each output beat with the oldest expected reading
            if (m_tvalid && m_tready) begin
                if (readings_due.size() == 0) begin
                    report("unexpected beat, quantity", m_tuser, -1);
                end
                else begin
                    want = readings_due.pop_front();
                    if (m_tuser !== want.qty)
                        report("quantity", m_tuser, want.qty);
                    if (m_tdata[22:0] !== want.inst)
                        report("instant_value", $signed(m_tdata[22:0]), want.inst);
                    if (m_tdata[45:23] !== want.filt)
                        report("filtered_value", $signed(m_tdata[45:23]), want.filt);
                    if (m_tlast !== want.last)
                        report("last_of_frame", m_tlast, want.last);
                end
            end
            if (cfg_we) begin
                if (cfg_index == afs_pkg::REG_CELL_ENABLE)
                    cells_on = cfg_data[0];
                else
                    gain[cfg_index - 1] = cfg_data;
            end
            if (s_tvalid && s_tready)
                process_frame(s_tuser, s_tdata);
        end
        pending = readings_due.size();
    end

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [191:0] s_tdata;   // sample_ch0 [23:0] .. sample_ch7 [191:168]
    logic [1:0]   s_tuser;   // kind
    logic         m_tvalid;
    logic         m_tready;
    logic [47:0]  m_tdata;   // instant_value [22:0], filtered_value [45:23], zeros
    logic [3:0]   m_tuser;   // quantity
    logic         m_tlast;
    logic         cfg_we;
    logic [2:0]   cfg_index;
    logic [15:0]  cfg_data;
    int           fail_count;
    int           pending;
    bit           steady;    // no idling on either side while set

    adc_frame_scale_filter_calibrate_unit dut (.*);

    afs_checker u_checker (.*);

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (steady || r < 65)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(20, 60);
    endfunction

    // Output side backpressure
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            m_tready = 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            if (!steady)
            begin
                m_tready = 1'b0;
                repeat (pick_gap()) @(negedge clk);
            end
        end
    end

    function automatic logic [23:0] pick_sample();
        case ($urandom_range(7))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'(int'($urandom_range(4000)) - 2000);
            3: return 24'($urandom_range(3000000));
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic send_frame(logic [1:0] kind, logic [191:0] d);
        int g;
        s_tuser  = kind;
        s_tdata  = d;
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        g = pick_gap();
        if (g > 0)
        begin
            s_tvalid = 1'b0;
            repeat (g) @(negedge clk);
        end
    endtask

    task automatic send_random(logic [1:0] kind);
        logic [191:0] d;
        for (int i = 0; i < afs_pkg::NUM_CH; i++)
            d[24*i +: 24] = pick_sample();
        send_frame(kind, d);
    endtask

    // Drain and let any calibration finish before touching registers
    task automatic settle();
        s_tvalid = 1'b0;
        wait (pending == 0);
        repeat (700) @(negedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic random_run(int n);
        int r;
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(99);
            if (r < 60)
                send_random(afs_pkg::KIND_MEAS);
            else if (r < 82)
                send_random(afs_pkg::KIND_CAL);
            else if (r < 92)
                send_random(afs_pkg::KIND_FINISH);
            else
                send_random(afs_pkg::KIND_IGNORE);
            // pause now and then until every reading is back
            if ($urandom_range(29) == 0)
                settle();
        end
    endtask

    initial
    begin
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = afs_pkg::KIND_IGNORE;
        cfg_we    = 1'b0;
        cfg_index = afs_pkg::REG_CELL_ENABLE;
        cfg_data  = '0;
        steady    = 1'b0;
        rst_n     = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: extremes under reset settings
        send_frame(afs_pkg::KIND_MEAS, {8{24'h7FFFFF}});
        send_frame(afs_pkg::KIND_MEAS, {8{24'h800000}});
        send_frame(afs_pkg::KIND_MEAS, '0);
        send_frame(afs_pkg::KIND_MEAS, {8{24'hFFFFFF}});
        send_frame(afs_pkg::KIND_IGNORE, {8{24'h7FFFFF}});
        send_frame(afs_pkg::KIND_MEAS, {8{24'h000001}});
        // calibration, then measure with offsets applied
        send_frame(afs_pkg::KIND_CAL, {8{24'h7FFFFF}});
        send_frame(afs_pkg::KIND_CAL, {8{24'h7FFFFE}});
        send_frame(afs_pkg::KIND_FINISH, {8{24'h7FFFFF}});
        send_frame(afs_pkg::KIND_MEAS, {8{24'h800000}});
        send_frame(afs_pkg::KIND_MEAS, '0);
        send_frame(afs_pkg::KIND_CAL, {8{24'hFFFFFD}});
        send_frame(afs_pkg::KIND_FINISH, {8{24'h000001}});
        send_frame(afs_pkg::KIND_MEAS, {8{24'h123456}});
        send_frame(afs_pkg::KIND_FINISH, {8{24'h800000}});
        send_frame(afs_pkg::KIND_MEAS, {8{24'h7FFFFF}});
        settle();

        // Cells off: current only
        write_reg(afs_pkg::REG_CELL_ENABLE, 16'd0);
        send_frame(afs_pkg::KIND_MEAS, {8{24'h7FFFFF}});
        send_frame(afs_pkg::KIND_MEAS, {8{24'h800000}});
        send_random(afs_pkg::KIND_MEAS);
        settle();

        // Gain extremes
        write_reg(afs_pkg::REG_CELL_ENABLE, 16'd1);
        for (int i = 1; i <= afs_pkg::NUM_CELLS_DEF; i++)
            write_reg(3'(i), 16'hFFFF);
        send_frame(afs_pkg::KIND_MEAS, {8{24'h7FFFFF}});
        send_frame(afs_pkg::KIND_MEAS, {8{24'h800000}});
        settle();
        for (int i = 1; i <= afs_pkg::NUM_CELLS_DEF; i++)
            write_reg(3'(i), 16'h0000);
        send_frame(afs_pkg::KIND_MEAS, {8{24'h7FFFFF}});
        settle();

        // Random, mixed gains
        for (int i = 1; i <= afs_pkg::NUM_CELLS_DEF; i++)
            write_reg(3'(i), 16'($urandom));
        random_run(60);
        settle();

        // Back to back calibration, finish and measure with no idling
        steady = 1'b1;
        send_frame(afs_pkg::KIND_CAL, {8{24'h7FFFFF}});
        send_frame(afs_pkg::KIND_CAL, {8{24'h800000}});
        send_frame(afs_pkg::KIND_FINISH, {8{24'h800000}});
        send_frame(afs_pkg::KIND_MEAS, {8{24'h7FFFFF}});
        steady = 1'b0;
        settle();

        // Cells toggled off, then back on with reset-like gains
        write_reg(afs_pkg::REG_CELL_ENABLE, 16'd0);
        random_run(30);
        settle();
        write_reg(afs_pkg::REG_CELL_ENABLE, 16'd1);
        for (int i = 1; i <= afs_pkg::NUM_CELLS_DEF; i++)
            write_reg(3'(i), 16'($urandom_range(30000, 36000)));
        steady = 1'b1;
        random_run(30);
        steady = 1'b0;
        random_run(70);

        // Wind down
        settle();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
